/* hdl/bounded_array_store_min_max_rotate_unit_assert.svh */
// Assertion macros used by the checker file of the array store.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BOUNDED_ARRAY_STORE_MIN_MAX_ROTATE_UNIT_ASSERT_SVH
`define BOUNDED_ARRAY_STORE_MIN_MAX_ROTATE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BASMMR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("array store check failed");

// Next-cycle implication.
`define BASMMR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("array store check failed");

`endif

/* hdl/basmmr_pkg.sv */
// Shared constants and types of the bounded array store.
// No dependencies; used by the top level, the modulo unit and the checker.
`timescale 1ns / 1ps

package basmmr_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int STEP_W = 16;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_READ    = 3'd2,
    OP_MIN     = 3'd3,
    OP_MAX     = 3'd4,
    OP_REVERSE = 3'd5,
    OP_ROTATE  = 3'd6,
    OP_CLEAR   = 3'd7
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

/* hdl/bounded_array_store_min_max_rotate_unit.sv */
// Bounded array store of signed 32-bit words with min, max, reverse and rotate.
// Depends on basmmr_pkg, basmmr_ram and basmmr_mod.
//
// Use: one operation beat enters on in_* (kind, value, index, step) under
// in_valid/in_ready; exactly one result beat leaves on out_* (result_value,
// status, fill_count) under out_valid/out_ready. in_ready is high only while
// the sequencer is idle; one operation is worked at a time.
// Operation flow (n = fill count):
//   push, clear, any error, empty rotate, reverse of under two words: straight to the result
//   pop, read: one RAM read, then the result
//   min, max: one word read a cycle from the single RAM read port, over n words
//   reverse: per swapped pair, read both words, then write both back
//   rotate: the remainder of step by n from basmmr_mod; unless it is zero,
//   three in-place reversals of swapped pairs (all words, the head, the tail)
// The next operation is taken the cycle after the result is loaded, even if
// the receiver has not yet taken it; a finished result then waits in the
// sequencer until the output register frees up. A stalled receiver holds
// out_* steady. Reset empties the store at once (fill count zero); the
// word memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module bounded_array_store_min_max_rotate_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic [9:0]         in_index,
  input  logic [15:0]        in_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status,
  output logic [10:0]        out_fill_count
);

  localparam int AW = basmmr_pkg::ADDR_W;
  localparam int CW = basmmr_pkg::CNT_W;
  localparam int WW = basmmr_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_MOD,
    S_REV_NEXT,
    S_REV_RB,
    S_REV_WA,
    S_REV_WB,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    PH_ALL,
    PH_HEAD,
    PH_TAIL
  } phase_t;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  basmmr_pkg::op_kind_t  kind_r, kind_nxt;
  basmmr_pkg::status_t   status_r, status_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic [AW-1:0]         lo_r, lo_nxt;
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [AW-1:0]         rot_r, rot_nxt;
  logic [WW-1:0]         best_r, best_nxt;
  logic [WW-1:0]         res_r, res_nxt;
  logic [WW-1:0]         tmp_r, tmp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WW-1:0]         out_value_r, out_value_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [CW-1:0]         out_fill_r, out_fill_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [WW-1:0]         ram_rdata;

  basmmr_pkg::mod_req_t  mod_req;
  basmmr_pkg::mod_rsp_t  mod_rsp;

  basmmr_ram #(
    .WIDTH (WW),
    .DEPTH (basmmr_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  basmmr_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    logic take;
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rot_nxt        = rot_r;
    best_nxt       = best_r;
    res_nxt        = res_r;
    tmp_nxt        = tmp_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    mod_req        = '0;
    take           = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = basmmr_pkg::op_kind_t'(in_kind);
          res_nxt    = '0;
          status_nxt = basmmr_pkg::ST_OK;
          state_nxt  = S_RESP;
          case (basmmr_pkg::op_kind_t'(in_kind))
            basmmr_pkg::OP_PUSH: begin
              if (count_r >= CW'(basmmr_pkg::DEPTH)) begin
                status_nxt = basmmr_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[AW-1:0];
                ram_wdata = in_value;
                count_nxt = count_r + 1'b1;
              end
            end
            basmmr_pkg::OP_POP: begin
              if (count_r == '0) begin
                status_nxt = basmmr_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                ram_re    = 1'b1;
                ram_raddr = count_nxt[AW-1:0];
                state_nxt = S_RD;
              end
            end
            basmmr_pkg::OP_READ: begin
              if (CW'(in_index) >= count_r) begin
                status_nxt = basmmr_pkg::ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_index);
                state_nxt = S_RD;
              end
            end
            basmmr_pkg::OP_MIN,
            basmmr_pkg::OP_MAX: begin
              if (count_r == '0) begin
                status_nxt = basmmr_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                scan_nxt  = CW'(1);
                state_nxt = S_SCAN;
              end
            end
            basmmr_pkg::OP_REVERSE: begin
              if (count_r >= CW'(2)) begin
                lo_nxt    = '0;
                hi_nxt    = AW'(count_r - 1'b1);
                phase_nxt = PH_TAIL;
                state_nxt = S_REV_NEXT;
              end
            end
            basmmr_pkg::OP_ROTATE: begin
              if (count_r != '0) begin
                mod_req.start    = 1'b1;
                mod_req.dividend = in_step;
                mod_req.divisor  = count_r;
                state_nxt        = S_MOD;
              end
            end
            basmmr_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = '0;
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt   = ram_rdata;
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        // data in hand belongs to address scan_r - 1
        if (kind_r == basmmr_pkg::OP_MAX) begin
          take = ($signed(best_r) < $signed(ram_rdata));
        end else begin
          take = ($signed(ram_rdata) < $signed(best_r));
        end
        if (scan_r == CW'(1) || take) begin
          best_nxt = ram_rdata;
        end
        if (scan_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = scan_r[AW-1:0];
          scan_nxt  = scan_r + 1'b1;
        end else begin
          res_nxt   = best_nxt;
          state_nxt = S_RESP;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem == '0) begin
            state_nxt = S_RESP;
          end else begin
            // rotate right = reverse all, then the head, then the tail
            rot_nxt   = mod_rsp.rem[AW-1:0];
            lo_nxt    = '0;
            hi_nxt    = AW'(count_r - 1'b1);
            phase_nxt = PH_ALL;
            state_nxt = S_REV_NEXT;
          end
        end
      end
      S_REV_NEXT: begin
        if (lo_r < hi_r) begin
          ram_re    = 1'b1;
          ram_raddr = lo_r;
          state_nxt = S_REV_RB;
        end else begin
          case (phase_r)
            PH_ALL: begin
              lo_nxt    = '0;
              hi_nxt    = rot_r - 1'b1;
              phase_nxt = PH_HEAD;
            end
            PH_HEAD: begin
              lo_nxt    = rot_r;
              hi_nxt    = AW'(count_r - 1'b1);
              phase_nxt = PH_TAIL;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_REV_RB: begin
        ram_re    = 1'b1;
        ram_raddr = hi_r;
        tmp_nxt   = ram_rdata;
        state_nxt = S_REV_WA;
      end
      S_REV_WA: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata;
        state_nxt = S_REV_WB;
      end
      S_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
        lo_nxt    = lo_r + 1'b1;
        hi_nxt    = hi_r - 1'b1;
        state_nxt = S_REV_NEXT;
      end
      S_RESP: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_status_nxt = status_r;
          out_fill_nxt   = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    phase_r      <= phase_nxt;
    kind_r       <= kind_nxt;
    status_r     <= status_nxt;
    scan_r       <= scan_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    rot_r        <= rot_nxt;
    best_r       <= best_nxt;
    res_r        <= res_nxt;
    tmp_r        <= tmp_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_fill_count   = out_fill_r;

endmodule

/* hdl/basmmr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module basmmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* hdl/basmmr_mod.sv */
// Iterative remainder unit: one restoring step per cycle over the dividend bits.
// Depends on basmmr_pkg for widths and the request and response structs.
`timescale 1ns / 1ps

module basmmr_mod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  basmmr_pkg::mod_req_t req,
  output basmmr_pkg::mod_rsp_t rsp
);

  localparam int STEP_CNT_W = $clog2(basmmr_pkg::STEP_W + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [STEP_CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [basmmr_pkg::STEP_W-1:0] dvd_r, dvd_nxt;
  logic [basmmr_pkg::CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [basmmr_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [basmmr_pkg::CNT_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[basmmr_pkg::STEP_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_CNT_W'(basmmr_pkg::STEP_W);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = basmmr_pkg::CNT_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = basmmr_pkg::CNT_W'(trial);
      end
      dvd_nxt = {dvd_r[basmmr_pkg::STEP_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

/* hdl/basmmr_checker.sv */
// Port-level checks of the bounded array store, bound to the top level.
// Depends on basmmr_pkg and bounded_array_store_min_max_rotate_unit_assert.svh.
`timescale 1ns / 1ps
`include "bounded_array_store_min_max_rotate_unit_assert.svh"

module basmmr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic [1:0]  out_status,
  input logic [10:0] out_fill_count
);

  // a stalled result beat stays put
  `BASMMR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_value) && $stable(out_status) && $stable(out_fill_count))

  // the sequencer is busy in the cycle after it takes an operation
  `BASMMR_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

  // full is only reported with the store at capacity
  `BASMMR_ASSERT_IMP(a_full_count, out_valid && out_status == basmmr_pkg::ST_FULL, out_fill_count == 11'(basmmr_pkg::DEPTH))

  // error results carry no word
  `BASMMR_ASSERT_IMP(a_err_zero, out_valid && out_status != basmmr_pkg::ST_OK, out_result_value == 32'd0)

endmodule

bind bounded_array_store_min_max_rotate_unit basmmr_checker u_basmmr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_status       (out_status),
  .out_fill_count   (out_fill_count)
);
